[rtl/assert_macros.svh]
// Assertion macros of the motor command frame packer RTL, used by mcfp_pipe_ctrl.
// No dependencies; each macro expands to one concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, disabled while the active-low reset is asserted.
`define MCFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, disabled while the active-low reset is asserted.
`define MCFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mcfp_pkg.sv]
// Package for the motor command frame packer: constants, register indexes and pipeline types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcfp_pkg;

  localparam int CODE_W                = 16;
  localparam int DEFAULT_FRACTION_BITS = 16;
  localparam int LIMIT_W               = 31;
  localparam int ID_W                  = 8;
  localparam int TYPE_W                = 5;
  localparam int CMD_W                 = 32;

  // Pipeline stage numbers: input register, clamp, numerator, then one stage per code bit.
  localparam int STG_FRONT  = 0;
  localparam int STG_CLAMP  = 1;
  localparam int STG_NUMER  = 2;
  localparam int STG_DIV0   = 3;
  localparam int NUM_STAGES = STG_DIV0 + CODE_W;

  // pi/180 in unsigned Q0.32, rounded to nearest.
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  localparam int STIFF_MAX_INT = 500;
  localparam int DAMP_MAX_INT  = 5;

  localparam logic [LIMIT_W-1:0] POS_LIMIT_RST = 31'd823788;
  localparam logic [LIMIT_W-1:0] VEL_LIMIT_RST = 31'd2883584;
  localparam logic [LIMIT_W-1:0] TRQ_LIMIT_RST = 31'd1114112;
  localparam logic [ID_W-1:0]    MOTOR_ID_RST  = 8'd1;
  localparam logic [TYPE_W-1:0]  FRAME_TYPE_RST = 5'd1;

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_POS_LIMIT  = 3'd0,
    REG_VEL_LIMIT  = 3'd1,
    REG_TRQ_LIMIT  = 3'd2,
    REG_DEG_MODE   = 3'd3,
    REG_DRIVE_EN   = 3'd4,
    REG_MOTOR_ID   = 3'd5,
    REG_FRAME_TYPE = 3'd6
  } cfg_reg_e;

  // Per-stage load enables of the elastic pipeline.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  // Width of a clamp bound: a 31-bit limit, or the largest gain maximum (500, 9 bits)
  // shifted up by the fraction bits.
  function automatic int bound_width(int fraction_bits);
    return (fraction_bits + 9 > 32) ? fraction_bits + 9 : 32;
  endfunction

endpackage

[rtl/mcfp_pipe_ctrl.sv]
// Valid tracking and per-stage load enables of the packer pipeline.
// Depends on mcfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcfp_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                enable_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcfp_pkg::pipe_ctrl_t ctrl_o
);
  import mcfp_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] load;
  logic                  push, pop;

  // A stage loads when it is empty or when its content moves on; bubbles collapse.
  assign load[LAST] = !valid_q[LAST] || out_ready_i;
  for (genvar k = 0; k < LAST; k++) begin : g_load
    assign load[k] = !valid_q[k] || load[k+1];
  end

  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i && enable_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[LAST];
  assign ctrl_o.load = load;

  assign push = in_valid_i && in_ready_o && enable_i;
  assign pop  = valid_q[LAST] && out_ready_i;

  `MCFP_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, &valid_q, "input stalled with a bubble in the pipeline")
  `MCFP_ASSERT(a_occupancy, clk_i, rst_ni, 1'b1 |=> ($countones(valid_q) == $past($countones(valid_q)) + int'($past(push)) - int'($past(pop))), "pipeline occupancy lost or gained a transaction")
  `MCFP_ASSERT(a_empty_output_fills, clk_i, rst_ni, (valid_q[LAST-1] && !valid_q[LAST]) |=> valid_q[LAST], "empty output stage did not take the next result")

endmodule

[rtl/mcfp_front.sv]
// Input register stage of the packer, with the degree to radian conversion of the position.
// Depends on mcfp_pkg.
`timescale 1ns / 1ps

module mcfp_front (
  input  logic                        clk_i,
  input  mcfp_pkg::pipe_ctrl_t        ctrl_i,
  input  logic                        degree_mode_i,
  input  logic signed [31:0]          position_i,
  input  logic signed [31:0]          velocity_i,
  input  logic signed [31:0]          torque_i,
  input  logic signed [31:0]          stiffness_i,
  input  logic signed [31:0]          damping_i,
  output logic signed [31:0]          position_o,
  output logic signed [31:0]          velocity_o,
  output logic signed [31:0]          torque_o,
  output logic signed [31:0]          stiffness_o,
  output logic signed [31:0]          damping_o
);
  import mcfp_pkg::*;

  logic signed [27:0] conv_k;
  logic signed [58:0] conv_prod;
  logic [63:0]        prod_d, prod_q;
  logic signed [31:0] vel_q, trq_q, kp_q, kd_q;

  // The position is kept as a Q.32 scaled product; without conversion it is shifted up by
  // 32 so that taking the upper word yields the floor in both cases.
  assign conv_k    = signed'({1'b0, DEG_TO_RAD_Q32});
  assign conv_prod = position_i * conv_k;
  assign prod_d    = degree_mode_i ? 64'(conv_prod) : {position_i, 32'd0};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_FRONT]) begin
      prod_q <= prod_d;
      vel_q  <= velocity_i;
      trq_q  <= torque_i;
      kp_q   <= stiffness_i;
      kd_q   <= damping_i;
    end
  end

  assign position_o  = signed'(prod_q[63:32]);
  assign velocity_o  = vel_q;
  assign torque_o    = trq_q;
  assign stiffness_o = kp_q;
  assign damping_o   = kd_q;

endmodule

[rtl/mcfp_lane.sv]
// One code lane: clamp to the bound and scale the clamped value into a 16-bit code. Symmetric
// lanes divide by the span, one quotient bit per stage; gain lanes divide by their constant
// maximum with a reciprocal multiplication. Depends on mcfp_pkg.
`timescale 1ns / 1ps

module mcfp_lane #(
  parameter int BOUND_W       = 32,
  parameter bit SYMMETRIC     = 1'b1,
  parameter int FRACTION_BITS = mcfp_pkg::DEFAULT_FRACTION_BITS,
  parameter int GAIN_MAX      = mcfp_pkg::DAMP_MAX_INT
) (
  input  logic                        clk_i,
  input  mcfp_pkg::pipe_ctrl_t        ctrl_i,
  input  logic signed [31:0]          value_i,
  input  logic [BOUND_W-1:0]          bound_i,
  output logic [mcfp_pkg::CODE_W-1:0] code_o
);
  import mcfp_pkg::*;

  localparam int DIV_W = BOUND_W + 1;
  localparam int NUM_W = DIV_W + CODE_W;
  localparam int SW    = BOUND_W + 2;

  // Gain lanes: the scaled gain is at most GAIN_MAX * 65535, which fits 25 bits for maxima
  // up to 512. With a 34-bit shift the rounded-up reciprocal gives the exact floor for the
  // maxima 5 and 500.
  localparam int GAIN_W    = 25;
  localparam int REC_SHIFT = 34;
  localparam int PROD_W    = GAIN_W + 32;
  localparam logic [31:0] REC_MUL =
    32'(((64'd1 << REC_SHIFT) + 64'(GAIN_MAX) - 64'd1) / 64'(GAIN_MAX));

  logic signed [SW-1:0] x_s, b_s, lo_s, c_s, u_s;
  logic [DIV_W-1:0]     off_d, off_q;
  logic [NUM_W-1:0]     scaled;

  // Symmetric lanes clamp to [-bound, bound] and offset by bound; gain lanes clamp to
  // [0, bound].
  always_comb begin
    x_s  = SW'(value_i);
    b_s  = signed'({2'b00, bound_i});
    lo_s = SYMMETRIC ? -b_s : '0;
    if (x_s > b_s) begin
      c_s = b_s;
    end else if (x_s < lo_s) begin
      c_s = lo_s;
    end else begin
      c_s = x_s;
    end
    u_s   = c_s - lo_s;
    off_d = u_s[DIV_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[STG_CLAMP]) begin
      off_q <= off_d;
    end
  end

  // Clamped offset * 65535 as a shift and a subtract.
  assign scaled = {off_q, CODE_W'(0)} - NUM_W'(off_q);

  if (SYMMETRIC) begin : g_sym
    logic [DIV_W-1:0]  dsr_d, dsr1_q;
    logic [NUM_W-1:0]  rem_q [CODE_W+1];
    logic [CODE_W-1:0] quo_q [CODE_W+1];
    logic [DIV_W-1:0]  dsr_q [CODE_W+1];

    // The span is twice the limit. A zero span is replaced by one so that the code comes
    // out zero.
    always_comb begin
      dsr_d = {bound_i, 1'b0};
      if (dsr_d == '0) begin
        dsr_d = DIV_W'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.load[STG_CLAMP]) begin
        dsr1_q <= dsr_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.load[STG_NUMER]) begin
        rem_q[0] <= scaled;
        quo_q[0] <= '0;
        dsr_q[0] <= dsr1_q;
      end
    end

    for (genvar k = 0; k < CODE_W; k++) begin : g_div
      localparam int BIT = CODE_W - 1 - k;
      logic [NUM_W-1:0]  trial;
      logic              take;
      logic [NUM_W-1:0]  rem_d;
      logic [CODE_W-1:0] quo_d;

      always_comb begin
        trial      = NUM_W'(dsr_q[k]) << BIT;
        take       = rem_q[k] >= trial;
        rem_d      = take ? rem_q[k] - trial : rem_q[k];
        quo_d      = quo_q[k];
        quo_d[BIT] = take;
      end

      always_ff @(posedge clk_i) begin
        if (ctrl_i.load[STG_DIV0 + k]) begin
          rem_q[k+1] <= rem_d;
          quo_q[k+1] <= quo_d;
          dsr_q[k+1] <= dsr_q[k];
        end
      end
    end

    assign code_o = quo_q[CODE_W];
  end else begin : g_gain
    logic [GAIN_W-1:0] gw_q;
    logic [PROD_W-1:0] gprod;
    logic [CODE_W-1:0] gcode_q [CODE_W];

    // floor(g * 65535 / (max << fraction bits)) is floor(floor(g * 65535 >> fraction bits)
    // / max); the second division is a multiplication by the reciprocal of the maximum.
    always_ff @(posedge clk_i) begin
      if (ctrl_i.load[STG_NUMER]) begin
        gw_q <= GAIN_W'(scaled >> FRACTION_BITS);
      end
    end

    assign gprod = PROD_W'(gw_q) * PROD_W'(REC_MUL);

    always_ff @(posedge clk_i) begin
      if (ctrl_i.load[STG_DIV0]) begin
        gcode_q[0] <= gprod[REC_SHIFT +: CODE_W];
      end
    end

    // The code rides along the remaining stages to stay in lockstep with the other lanes.
    for (genvar k = 1; k < CODE_W; k++) begin : g_delay
      always_ff @(posedge clk_i) begin
        if (ctrl_i.load[STG_DIV0 + k]) begin
          gcode_q[k] <= gcode_q[k-1];
        end
      end
    end

    assign code_o = gcode_q[CODE_W-1];
  end

endmodule

[rtl/motor_command_frame_packer.sv]
// Motor command frame packer: five scaling lanes turn one motor command into one extended
// CAN frame. Top level; depends on mcfp_pkg, mcfp_pipe_ctrl, mcfp_front and mcfp_lane.
`timescale 1ns / 1ps

// The command stream enters on s_axis (position, velocity, torque, stiffness and damping,
// each signed fixed point with FRACTION_BITS fraction bits) and the frame leaves on m_axis
// as a 29-bit identifier and an 8-byte big-endian payload. The user sets limits, angle mode,
// drive enable, motor id and frame type over the APB port only while no transaction is in
// flight (not enforced by the block); with the drive off, commands are taken and dropped.
//
// The command is registered at the accepting edge in the input stage (with the 32x27 degree
// to radian multiplier), then passes one clamp stage, one scaling stage and sixteen code
// stages. In the position, velocity and torque lanes each code stage settles one quotient
// bit of the division by the span; the gain lanes divide by their constant maximum with one
// reciprocal multiply and carry the code through the remaining stages. All five lanes run
// in lockstep, so a new command is taken every cycle while s_axis_tready is high. When the
// receiver stalls, the result waits in the last stage and earlier stages keep filling
// until every stage holds a command; only then does s_axis_tready drop. Reset empties the
// pipeline and loads the default register values.
// Every code is floor(u * 65535 / span), where u is the clamped value offset into
// [0, span]; a symmetric lane spans twice its limit, a gain lane spans its maximum.

module motor_command_frame_packer #(
  parameter int FRACTION_BITS = mcfp_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command stream. tdata from bit 0 up: target_position, target_velocity,
  // feedforward_torque, stiffness_gain, damping_gain (32 bits each).
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [159:0]                 s_axis_tdata,
  // Frame stream. tdata from bit 0 up: frame_identifier (29), frame_payload (64), zero pad (3).
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [95:0]                  m_axis_tdata,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mcfp_pkg::*;

  localparam int BOUND_W = bound_width(FRACTION_BITS);
  localparam logic [BOUND_W-1:0] STIFF_TOP = BOUND_W'(STIFF_MAX_INT) << FRACTION_BITS;
  localparam logic [BOUND_W-1:0] DAMP_TOP  = BOUND_W'(DAMP_MAX_INT) << FRACTION_BITS;

  // Configuration registers.
  logic [LIMIT_W-1:0] pos_limit_q, vel_limit_q, trq_limit_q;
  logic               deg_mode_q, drive_en_q;
  logic [ID_W-1:0]    motor_id_q;
  logic [TYPE_W-1:0]  frame_type_q;
  logic               wr_en;
  cfg_reg_e           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_limit_q  <= POS_LIMIT_RST;
      vel_limit_q  <= VEL_LIMIT_RST;
      trq_limit_q  <= TRQ_LIMIT_RST;
      deg_mode_q   <= 1'b0;
      drive_en_q   <= 1'b0;
      motor_id_q   <= MOTOR_ID_RST;
      frame_type_q <= FRAME_TYPE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POS_LIMIT:  pos_limit_q  <= pwdata[LIMIT_W-1:0];
        REG_VEL_LIMIT:  vel_limit_q  <= pwdata[LIMIT_W-1:0];
        REG_TRQ_LIMIT:  trq_limit_q  <= pwdata[LIMIT_W-1:0];
        REG_DEG_MODE:   deg_mode_q   <= pwdata[0];
        REG_DRIVE_EN:   drive_en_q   <= pwdata[0];
        REG_MOTOR_ID:   motor_id_q   <= pwdata[ID_W-1:0];
        REG_FRAME_TYPE: frame_type_q <= pwdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POS_LIMIT:  prdata = 32'(pos_limit_q);
      REG_VEL_LIMIT:  prdata = 32'(vel_limit_q);
      REG_TRQ_LIMIT:  prdata = 32'(trq_limit_q);
      REG_DEG_MODE:   prdata = 32'(deg_mode_q);
      REG_DRIVE_EN:   prdata = 32'(drive_en_q);
      REG_MOTOR_ID:   prdata = 32'(motor_id_q);
      REG_FRAME_TYPE: prdata = 32'(frame_type_q);
      default:        prdata = '0;
    endcase
  end

  // Pipeline control shared by the input stage and all lanes.
  pipe_ctrl_t pipe_ctrl;

  mcfp_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .enable_i    (drive_en_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (pipe_ctrl)
  );

  logic signed [CMD_W-1:0] pos_f, vel_f, trq_f, kp_f, kd_f;

  mcfp_front u_front (
    .clk_i         (clk_i),
    .ctrl_i        (pipe_ctrl),
    .degree_mode_i (deg_mode_q),
    .position_i    (signed'(s_axis_tdata[31:0])),
    .velocity_i    (signed'(s_axis_tdata[63:32])),
    .torque_i      (signed'(s_axis_tdata[95:64])),
    .stiffness_i   (signed'(s_axis_tdata[127:96])),
    .damping_i     (signed'(s_axis_tdata[159:128])),
    .position_o    (pos_f),
    .velocity_o    (vel_f),
    .torque_o      (trq_f),
    .stiffness_o   (kp_f),
    .damping_o     (kd_f)
  );

  logic [CODE_W-1:0] pos_code, vel_code, trq_code, kp_code, kd_code;

  mcfp_lane #(.BOUND_W(BOUND_W), .SYMMETRIC(1'b1)) u_lane_pos (
    .clk_i   (clk_i),
    .ctrl_i  (pipe_ctrl),
    .value_i (pos_f),
    .bound_i (BOUND_W'(pos_limit_q)),
    .code_o  (pos_code)
  );

  mcfp_lane #(.BOUND_W(BOUND_W), .SYMMETRIC(1'b1)) u_lane_vel (
    .clk_i   (clk_i),
    .ctrl_i  (pipe_ctrl),
    .value_i (vel_f),
    .bound_i (BOUND_W'(vel_limit_q)),
    .code_o  (vel_code)
  );

  mcfp_lane #(.BOUND_W(BOUND_W), .SYMMETRIC(1'b1)) u_lane_trq (
    .clk_i   (clk_i),
    .ctrl_i  (pipe_ctrl),
    .value_i (trq_f),
    .bound_i (BOUND_W'(trq_limit_q)),
    .code_o  (trq_code)
  );

  mcfp_lane #(
    .BOUND_W       (BOUND_W),
    .SYMMETRIC     (1'b0),
    .FRACTION_BITS (FRACTION_BITS),
    .GAIN_MAX      (STIFF_MAX_INT)
  ) u_lane_kp (
    .clk_i   (clk_i),
    .ctrl_i  (pipe_ctrl),
    .value_i (kp_f),
    .bound_i (STIFF_TOP),
    .code_o  (kp_code)
  );

  mcfp_lane #(
    .BOUND_W       (BOUND_W),
    .SYMMETRIC     (1'b0),
    .FRACTION_BITS (FRACTION_BITS),
    .GAIN_MAX      (DAMP_MAX_INT)
  ) u_lane_kd (
    .clk_i   (clk_i),
    .ctrl_i  (pipe_ctrl),
    .value_i (kd_f),
    .bound_i (DAMP_TOP),
    .code_o  (kd_code)
  );

  // Frame assembly: the identifier carries type, torque code and motor id; the payload
  // carries position, velocity, stiffness and damping codes, first byte in the top bits.
  logic [28:0] frame_identifier;
  logic [63:0] frame_payload;

  assign frame_identifier = {frame_type_q, trq_code, motor_id_q};
  assign frame_payload    = {pos_code, vel_code, kp_code, kd_code};
  assign m_axis_tdata     = {3'b000, frame_payload, frame_identifier};

endmodule

[verif/mcfp_frame_checker.sv]
// Scoreboard for the motor command frame packer: mirrors the register file from APB writes,
// predicts the frame of every command accepted while the drive is enabled and compares it
// with the frame stream. Depends on mcfp_pkg.
`timescale 1ns / 1ps

module mcfp_frame_checker #(
  parameter int FRACTION_BITS = mcfp_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  logic                         cmd_ready_i,
  input  logic [159:0]                 cmd_data_i,
  input  logic                         frame_valid_i,
  input  logic                         frame_ready_i,
  input  logic [95:0]                  frame_data_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mcfp_pkg::PADDR_W-1:0] paddr_i,
  input  logic [31:0]                  pwdata_i,
  input  logic                         pready_i,
  output int                           mismatch_count_o,
  output int                           frames_pending_o
);

  import mcfp_pkg::*;

  typedef struct packed {
    logic [28:0] ident;
    logic [63:0] payload;
  } frame_t;

  frame_t expected_frames[$];

  logic [LIMIT_W-1:0] pos_limit, vel_limit, trq_limit;
  logic               deg_mode, drive_on;
  logic [ID_W-1:0]    motor_id;
  logic [TYPE_W-1:0]  frame_type;
  int                 mismatches = 0;

  // floor(x * pi/180); the product stays below 2^58, so a 64-bit arithmetic shift is exact.
  function automatic longint to_radians(input longint x);
    longint prod;
    prod = x * longint'(DEG_TO_RAD_Q32);
    return prod >>> 32;
  endfunction

  function automatic logic [15:0] symmetric_code(input longint x, input logic [LIMIT_W-1:0] lim);
    longint     l;
    logic [63:0] num;
    l = longint'(lim);
    if (l == 0) return '0;
    if (x > l) x = l;
    if (x < -l) x = -l;
    num = 64'(x + l) * 64'd65535;
    return 16'(num / (64'(l) * 64'd2));
  endfunction

  function automatic logic [15:0] gain_code(input longint g, input int max_int);
    logic [63:0] top_v, v;
    top_v = 64'(max_int) << FRACTION_BITS;
    if (g < 0) return '0;
    v = 64'(g);
    if (v > top_v) v = top_v;
    return 16'((v * 64'd65535) / top_v);
  endfunction

  function automatic frame_t pack_frame(input logic [159:0] c);
    longint      pos;
    logic [15:0] pc, vc, tc, kpc, kdc;
    frame_t      f;
    pos = longint'($signed(c[31:0]));
    if (deg_mode) pos = to_radians(pos);
    pc  = symmetric_code(pos, pos_limit);
    vc  = symmetric_code(longint'($signed(c[63:32])), vel_limit);
    tc  = symmetric_code(longint'($signed(c[95:64])), trq_limit);
    kpc = gain_code(longint'($signed(c[127:96])), STIFF_MAX_INT);
    kdc = gain_code(longint'($signed(c[159:128])), DAMP_MAX_INT);
    f.ident   = {frame_type, tc, motor_id};
    f.payload = {pc, vc, kpc, kdc};
    return f;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      pos_limit  <= POS_LIMIT_RST;
      vel_limit  <= VEL_LIMIT_RST;
      trq_limit  <= TRQ_LIMIT_RST;
      deg_mode   <= 1'b0;
      drive_on   <= 1'b0;
      motor_id   <= MOTOR_ID_RST;
      frame_type <= FRAME_TYPE_RST;
      expected_frames.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_POS_LIMIT:  pos_limit  <= pwdata_i[LIMIT_W-1:0];
          REG_VEL_LIMIT:  vel_limit  <= pwdata_i[LIMIT_W-1:0];
          REG_TRQ_LIMIT:  trq_limit  <= pwdata_i[LIMIT_W-1:0];
          REG_DEG_MODE:   deg_mode   <= pwdata_i[0];
          REG_DRIVE_EN:   drive_on   <= pwdata_i[0];
          REG_MOTOR_ID:   motor_id   <= pwdata_i[ID_W-1:0];
          REG_FRAME_TYPE: frame_type <= pwdata_i[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i && drive_on)
        expected_frames.push_back(pack_frame(cmd_data_i));
      if (frame_valid_i && frame_ready_i) begin
        if (expected_frames.size() == 0) begin
          note_mismatch("unexpected frame", '0, frame_data_i[92:29]);
        end else begin
          want = expected_frames.pop_front();
          if (frame_data_i[28:0] !== want.ident)
            note_mismatch("frame_identifier", 64'(want.ident), 64'(frame_data_i[28:0]));
          if (frame_data_i[92:29] !== want.payload)
            note_mismatch("frame_payload", want.payload, frame_data_i[92:29]);
          if (frame_data_i[95:93] !== 3'b000)
            note_mismatch("tdata padding", '0, 64'(frame_data_i[95:93]));
        end
      end
    end
    mismatch_count_o <= mismatches;
    frames_pending_o <= expected_frames.size();
  end

endmodule

[verif/tb_motor_command_frame_packer.sv]
// Testbench top for the motor command frame packer: clock, reset, APB register setup and
// command stimulus with random stalls. Depends on mcfp_pkg, the block and mcfp_frame_checker.
`timescale 1ns / 1ps

module tb_motor_command_frame_packer;

  import mcfp_pkg::*;

  // Cycles from command transaction to frame valid, used as the drain allowance.
  localparam int LATENCY       = 18;
  localparam int IDLE_PCT      = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int FRAC          = DEFAULT_FRACTION_BITS;

  // Address just past the register map; a write there must change nothing.
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 5'd28;

  // Handy values at the reset limits and the gain maxima.
  localparam int POS_L    = 823788;
  localparam int VEL_L    = 2883584;
  localparam int TRQ_L    = 1114112;
  localparam int STIFF_TOP = STIFF_MAX_INT << FRAC;
  localparam int DAMP_TOP  = DAMP_MAX_INT << FRAC;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [159:0]        s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [95:0]         m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int mismatch_count;
  int frames_pending;

  // Shared stimulus controls: quiet turns off idling on both sides, hold_kick asks the
  // frame sink for one long hold-off.
  logic quiet = 1'b0;
  logic hold_kick = 1'b0;

  // Register values as last written, used only to aim the random commands.
  logic [LIMIT_W-1:0] pos_lim = POS_LIMIT_RST;
  logic [LIMIT_W-1:0] vel_lim = VEL_LIMIT_RST;
  logic [LIMIT_W-1:0] trq_lim = TRQ_LIMIT_RST;
  logic               deg_on = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  motor_command_frame_packer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  mcfp_frame_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cmd_valid_i      (s_tvalid),
    .cmd_ready_i      (s_tready),
    .cmd_data_i       (s_tdata),
    .frame_valid_i    (m_tvalid),
    .frame_ready_i    (m_tready),
    .frame_data_i     (m_tdata),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .frames_pending_o (frames_pending)
  );

  // Frame sink. It drops tready about one cycle in ten, never while the quiet flag is set,
  // and once, on request, holds off for a long stretch so that the pipeline fills and the
  // block has to stall the command stream.
  initial begin : frame_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // One APB write: setup phase, access phase until pready, then idle with psel low so that
  // the next write starts its setup phase cleanly.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [31:0] v);
    apb_write({r, 2'b00}, v);
    case (r)
      REG_POS_LIMIT: pos_lim = v[LIMIT_W-1:0];
      REG_VEL_LIMIT: vel_lim = v[LIMIT_W-1:0];
      REG_TRQ_LIMIT: trq_lim = v[LIMIT_W-1:0];
      REG_DEG_MODE:  deg_on = v[0];
      default: ;
    endcase
  endtask

  // Offers one command and returns once the transaction has taken place. tvalid stays high
  // afterwards, so back-to-back commands never lower it; only a random gap does.
  task automatic send_cmd(input logic [31:0] pos, input logic [31:0] vel,
                          input logic [31:0] trq, input logic [31:0] kp,
                          input logic [31:0] kd);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {kd, kp, trq, vel, pos};
    do @(posedge clk); while (!s_tready);
  endtask

  // Ends a burst of commands and waits until every predicted frame has come out, plus the
  // pipeline depth, since commands sent while the drive is off leave no expectation behind.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mostly a value in [lo, hi]; now and then anything at all or one of the 32-bit extremes.
  function automatic logic [31:0] rand_field(input longint lo, input longint hi);
    logic [63:0] draw;
    if (lo < -64'sh8000_0000) lo = -64'sh8000_0000;
    if (hi > 64'sh7fff_ffff) hi = 64'sh7fff_ffff;
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        draw = {$urandom, $urandom};
        return 32'(lo + longint'(draw % 64'(hi - lo + 1)));
      end
    endcase
  endfunction

  // A command aimed at the clamp edges of the current limits. In degree mode the position
  // range is widened by about 180/pi so that it still reaches the radian limit.
  task automatic send_random;
    longint ps, vs, ts;
    ps = longint'(pos_lim) * (deg_on ? 58 : 1);
    ps = ps + ps / 8 + 1;
    vs = longint'(vel_lim) + longint'(vel_lim) / 8 + 1;
    ts = longint'(trq_lim) + longint'(trq_lim) / 8 + 1;
    send_cmd(rand_field(-ps, ps), rand_field(-vs, vs), rand_field(-ts, ts),
             rand_field(-STIFF_TOP / 16, STIFF_TOP + STIFF_TOP / 16),
             rand_field(-DAMP_TOP / 16, DAMP_TOP + DAMP_TOP / 16));
  endtask

  // Limit values: the extremes, full random words (bit 31 is dropped by the register, and a
  // word that masks to zero gives the zero-limit case) and typical magnitudes.
  function automatic logic [31:0] pick_limit();
    case ($urandom_range(5))
      0: return 32'd1;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      3: return $urandom_range(32'h1000, 32'h100_0000);
      default: return $urandom_range(32'h1_0000, 32'h40_0000);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The drive is off after reset: these commands must be swallowed without a frame.
    repeat (5) send_random();
    drain();

    // Directed commands at the default limits: all-zero, 32-bit extremes, exact limits,
    // one past them, and gains negative, at and above their maxima.
    write_reg(REG_DRIVE_EN, 32'h1);
    send_cmd(0, 0, 0, 0, 0);
    send_cmd(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cmd(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(POS_L, VEL_L, TRQ_L, STIFF_TOP, DAMP_TOP);
    send_cmd(-POS_L, -VEL_L, -TRQ_L, STIFF_TOP - 1, DAMP_TOP - 1);
    send_cmd(POS_L + 1, -VEL_L - 1, TRQ_L + 1, STIFF_TOP + 1, DAMP_TOP + 1);
    send_cmd(-POS_L + 1, 1, -1, -STIFF_TOP, -DAMP_TOP);
    drain();

    // Degree mode: the position is converted before clamping.
    write_reg(REG_DEG_MODE, 32'h1);
    send_cmd(720 << FRAC, 0, 0, STIFF_TOP / 2, DAMP_TOP / 2);
    send_cmd(-(180 << FRAC), 0, 0, 1, 1);
    send_cmd(32'h7fff_ffff, 0, 0, 0, 0);
    send_cmd(32'h8000_0000, 0, 0, 0, 0);
    send_cmd(1 << FRAC, -(1 << FRAC), 1 << FRAC, 0, 0);
    drain();

    // Zero limits: bit 31 is outside the register, so these writes leave a limit of zero
    // and every symmetric code must come out as zero.
    write_reg(REG_DEG_MODE, 32'h0);
    write_reg(REG_POS_LIMIT, 32'h8000_0000);
    write_reg(REG_VEL_LIMIT, 32'h8000_0000);
    write_reg(REG_TRQ_LIMIT, 32'h8000_0000);
    send_cmd(0, 0, 0, 0, 0);
    send_cmd(32'h7fff_ffff, 32'h8000_0000, 5, STIFF_TOP, DAMP_TOP);
    drain();

    // Smallest nonzero limits.
    write_reg(REG_POS_LIMIT, 32'h1);
    write_reg(REG_VEL_LIMIT, 32'h1);
    write_reg(REG_TRQ_LIMIT, 32'h1);
    send_cmd(1, -1, 0, 0, 0);
    send_cmd(2, -2, -1, 1, 1);
    drain();

    // Largest limits; the write to the unmapped address must leave them alone.
    write_reg(REG_POS_LIMIT, 32'h7fff_ffff);
    write_reg(REG_VEL_LIMIT, 32'h7fff_ffff);
    write_reg(REG_TRQ_LIMIT, 32'h7fff_ffff);
    apb_write(UNMAPPED_ADDR, 32'h0);
    send_cmd(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_cmd(32'h8000_0001, 32'h7fff_fffe, 32'h8000_0000, 0, 0);
    drain();

    // Random content with the drive off again: nothing may come out.
    write_reg(REG_DRIVE_EN, 32'hffff_fffe);
    repeat (40) send_random();
    drain();

    // Random phases, each with fresh register settings. Phase 0 and 1 take the extremes of
    // motor id and frame type, phase 2 runs without any idling, and phase 4 carries the
    // long hold-off on the frame side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_POS_LIMIT, pick_limit());
      write_reg(REG_VEL_LIMIT, pick_limit());
      write_reg(REG_TRQ_LIMIT, pick_limit());
      v = $urandom;
      v[0] = $urandom_range(1);
      write_reg(REG_DEG_MODE, v);
      v = $urandom;
      v[0] = 1'b1;
      write_reg(REG_DRIVE_EN, v);
      write_reg(REG_MOTOR_ID, (p == 0) ? 32'h0 : (p == 1) ? 32'hff : $urandom);
      write_reg(REG_FRAME_TYPE, (p == 0) ? 32'h0 : (p == 1) ? 32'h1f : $urandom);
      quiet     <= (p == 2);
      hold_kick <= (p == 4);
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
